/* src/efd_pkg.sv */
package efd_pkg;

    // link symbols
    localparam logic [7:0] SYM_HEADER = 8'h7D;
    localparam logic [7:0] SYM_END    = 8'h7E;
    localparam logic [7:0] SYM_ESC    = 8'h7F;

    // codes that may follow the escape byte
    localparam logic [7:0] ESC_CODE_HEADER = 8'h01;
    localparam logic [7:0] ESC_CODE_END    = 8'h02;
    localparam logic [7:0] ESC_CODE_ESC    = 8'h03;

    // result kinds
    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_ACCEPT  = 2'd1;
    localparam logic [1:0] EV_ABANDON = 2'd2;

    // frame classes from the type byte
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // abandon causes
    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_BAD_ESC   = 2'd1;
    localparam logic [1:0] CAUSE_OVERFLOW  = 2'd2;
    localparam logic [1:0] CAUSE_RESTARTED = 2'd3;

    localparam int POSITION_W = 10;
    localparam int LENGTH_W   = 11;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BEGIN,
        PH_ESCAPE,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic [1:0]            abandon_cause;
        logic                  reply_ack;
        logic [7:0]            command_code;
        logic [1:0]            frame_kind;
        logic [LENGTH_W-1:0]   frame_length;
        logic [POSITION_W-1:0] position;
        logic [7:0]            data_byte;
        logic [1:0]            event_res;
    } t_result;

endpackage

/* src/escaped_frame_deframer.sv */
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: see port, tuser[1:0] event_res
//
// one item per cycle while the result side keeps up; the frame state machine
// decodes the byte in the cycle it is taken and the result appears from the
// output register on the next cycle
// input is taken while the output register is empty or being drained, so a
// stall on the result side holds the input side only while a result waits
// synchronous active-low reset returns the deframer to idle with a zero count
module escaped_frame_deframer #(
    parameter int MAX_FRAME = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] data_byte, [17:8] position,
                                        // [28:18] frame_length, [30:29] frame_kind,
                                        // [38:31] command_code, [39] reply_ack,
                                        // [41:40] abandon_cause, [47:42] zero
    output logic [1:0]  m_axis_tuser    // [1:0] event_res
);

    // count must hold MAX_FRAME itself
    localparam int CW = $clog2(MAX_FRAME + 1);

    efd_pkg::t_phase  r_phase, n_phase;
    logic [CW-1:0]    r_write_count, n_write_count;
    logic [7:0]       r_type_byte, n_type_byte;
    logic [7:0]       r_second_byte, n_second_byte;
    logic             r_overflowed, n_overflowed;

    logic             r_out_valid;
    efd_pkg::t_result r_out;
    efd_pkg::t_result w_res;
    logic             w_res_valid;

    logic             w_accept;
    logic [7:0]       w_byte;

    // decode helpers for the next-state and output logic
    logic             w_store;      // a decoded byte goes into the frame
    logic [7:0]       w_store_val;
    logic             w_full;
    logic             w_esc_ok;
    logic [7:0]       w_esc_val;
    logic [31:0]      w_count_ext;
    logic [1:0]       w_kind;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_byte        = s_axis_tdata;
    assign w_full        = (r_write_count >= CW'(MAX_FRAME));
    assign w_count_ext   = 32'(r_write_count);
    assign w_kind        = (r_type_byte <= 8'd2) ? r_type_byte[1:0] : efd_pkg::KIND_UNKNOWN;

    // escape code to byte value
    always_comb begin
        w_esc_ok  = 1'b1;
        w_esc_val = 8'h00;
        unique case (w_byte)
            efd_pkg::ESC_CODE_HEADER: w_esc_val = efd_pkg::SYM_HEADER;
            efd_pkg::ESC_CODE_END:    w_esc_val = efd_pkg::SYM_END;
            efd_pkg::ESC_CODE_ESC:    w_esc_val = efd_pkg::SYM_ESC;
            default:                  w_esc_ok  = 1'b0;
        endcase
    end

    // does this byte carry frame content
    always_comb begin
        w_store     = 1'b0;
        w_store_val = w_byte;
        unique case (r_phase)
            efd_pkg::PH_BEGIN, efd_pkg::PH_PAYLOAD: begin
                w_store = (w_byte != efd_pkg::SYM_HEADER) && (w_byte != efd_pkg::SYM_END)
                       && (w_byte != efd_pkg::SYM_ESC);
            end
            efd_pkg::PH_ESCAPE: begin
                w_store     = w_esc_ok;
                w_store_val = w_esc_val;
            end
            default: w_store = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_write_count = r_write_count;
        n_type_byte   = r_type_byte;
        n_second_byte = r_second_byte;
        n_overflowed  = r_overflowed;
        if (w_accept) begin
            if (w_byte == efd_pkg::SYM_HEADER) begin
                // a header restarts from any phase
                n_phase       = efd_pkg::PH_BEGIN;
                n_write_count = '0;
                n_overflowed  = 1'b0;
            end else if (w_store) begin
                n_phase = efd_pkg::PH_PAYLOAD;
                if (w_full) begin
                    n_overflowed = 1'b1;
                end else begin
                    n_write_count = r_write_count + CW'(1);
                    if (r_write_count == '0) begin
                        n_type_byte = w_store_val;
                    end
                    if (r_write_count == CW'(1)) begin
                        n_second_byte = w_store_val;
                    end
                end
            end else begin
                unique case (r_phase)
                    efd_pkg::PH_IDLE: n_phase = efd_pkg::PH_IDLE;
                    efd_pkg::PH_BEGIN, efd_pkg::PH_PAYLOAD: begin
                        // end closes the frame, escape opens an escape pair
                        n_phase = (w_byte == efd_pkg::SYM_ESC) ? efd_pkg::PH_ESCAPE
                                                               : efd_pkg::PH_IDLE;
                    end
                    efd_pkg::PH_ESCAPE: n_phase = efd_pkg::PH_IDLE;
                    default:            n_phase = efd_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // result for the byte taken this cycle
    always_comb begin
        w_res_valid = 1'b0;
        w_res       = '0;
        unique case (r_phase)
            efd_pkg::PH_IDLE: w_res_valid = 1'b0;
            efd_pkg::PH_BEGIN: begin
                if (w_store && !w_full) begin
                    w_res_valid     = 1'b1;
                    w_res.event_res = efd_pkg::EV_BYTE;
                    w_res.data_byte = w_store_val;
                    w_res.position  = w_count_ext[efd_pkg::POSITION_W-1:0];
                end
            end
            efd_pkg::PH_ESCAPE, efd_pkg::PH_PAYLOAD: begin
                if (w_byte == efd_pkg::SYM_HEADER) begin
                    w_res_valid         = 1'b1;
                    w_res.event_res     = efd_pkg::EV_ABANDON;
                    w_res.abandon_cause = efd_pkg::CAUSE_RESTARTED;
                end else if (w_store) begin
                    if (!w_full) begin
                        w_res_valid     = 1'b1;
                        w_res.event_res = efd_pkg::EV_BYTE;
                        w_res.data_byte = w_store_val;
                        w_res.position  = w_count_ext[efd_pkg::POSITION_W-1:0];
                    end
                end else if (r_phase == efd_pkg::PH_ESCAPE) begin
                    w_res_valid         = 1'b1;
                    w_res.event_res     = efd_pkg::EV_ABANDON;
                    w_res.abandon_cause = efd_pkg::CAUSE_BAD_ESC;
                end else if (w_byte == efd_pkg::SYM_END) begin
                    w_res_valid = 1'b1;
                    if (r_overflowed) begin
                        w_res.event_res     = efd_pkg::EV_ABANDON;
                        w_res.abandon_cause = efd_pkg::CAUSE_OVERFLOW;
                    end else begin
                        w_res.event_res    = efd_pkg::EV_ACCEPT;
                        w_res.frame_length = w_count_ext[efd_pkg::LENGTH_W-1:0];
                        w_res.frame_kind   = w_kind;
                        if (w_kind == efd_pkg::KIND_COMMAND) begin
                            w_res.reply_ack    = 1'b1;
                            w_res.command_code = (r_write_count >= CW'(2)) ? r_second_byte
                                                                           : 8'h00;
                        end
                    end
                end
            end
            default: w_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= efd_pkg::PH_IDLE;
            r_write_count <= '0;
            r_type_byte   <= 8'h00;
            r_second_byte <= 8'h00;
            r_overflowed  <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_write_count <= n_write_count;
            r_type_byte   <= n_type_byte;
            r_second_byte <= n_second_byte;
            r_overflowed  <= n_overflowed;
        end
    end

    // output register, refilled on any accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tdata  = {6'b0, r_out.abandon_cause, r_out.reply_ack, r_out.command_code,
                            r_out.frame_kind, r_out.frame_length, r_out.position,
                            r_out.data_byte};

    // count never runs past the frame limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_count <= CW'(MAX_FRAME))
        else $error("write count above frame limit");

    // a header always opens a fresh frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_byte == efd_pkg::SYM_HEADER)
        |=> (r_phase == efd_pkg::PH_BEGIN) && (r_write_count == '0) && !r_overflowed)
        else $error("header did not restart frame");

    // escape inside a frame waits for its code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_byte == efd_pkg::SYM_ESC)
        && ((r_phase == efd_pkg::PH_BEGIN) || (r_phase == efd_pkg::PH_PAYLOAD))
        |=> (r_phase == efd_pkg::PH_ESCAPE) && !r_out_valid)
        else $error("escape byte mishandled");

    // reply request only on accepted command frames
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.reply_ack
        |-> (r_out.event_res == efd_pkg::EV_ACCEPT)
            && (r_out.frame_kind == efd_pkg::KIND_COMMAND))
        else $error("reply ack on wrong result");

endmodule
